/* hw/rtl/kpd_pkg.sv */
// key press event detector package
// record, phase, event and register index types plus reset constants and click limits
// no dependencies
`default_nettype none

package kpd_pkg;

   typedef enum logic [1:0] {
      PH_RELEASED = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_PRESSED  = 2'd2,
      PH_LONG     = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2,
      EV_MULTI = 2'd3
   } event_type;

   typedef enum logic [2:0] {
      CSR_RELEASE_TRIGGER = 3'd0,
      CSR_SHORT_ENABLE    = 3'd1,
      CSR_LONG_ENABLE     = 3'd2,
      CSR_MULTI_ENABLE    = 3'd3,
      CSR_DEBOUNCE_MS     = 3'd4,
      CSR_LONG_PRESS_MS   = 3'd5,
      CSR_CLICK_GAP_MS    = 3'd6
   } csr_index_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] press_start_time;
      logic [31:0] release_time;
      logic [7:0]  click_tally;
      logic        held_flag;
      logic        short_fired;
      logic        long_fired;
   } key_rec_type;

   localparam key_rec_type KEY_REC_RESET = '{
      phase:            PH_RELEASED,
      press_start_time: 32'd0,
      release_time:     32'd0,
      click_tally:      8'd0,
      held_flag:        1'b0,
      short_fired:      1'b0,
      long_fired:       1'b0
   };

   localparam logic [7:0]  RELEASE_TRIGGER_RESET = 8'hFF;
   localparam logic [15:0] DEBOUNCE_MS_RESET     = 16'd10;
   localparam logic [15:0] LONG_PRESS_MS_RESET   = 16'd1000;
   localparam logic [15:0] CLICK_GAP_MS_RESET    = 16'd300;
   localparam logic [7:0]  MULTI_MIN_CLICKS      = 8'd2;
   localparam logic [7:0]  TALLY_MAX             = 8'hFF;

endpackage

`default_nettype wire

/* hw/rtl/key_press_event_detector.sv */
// key press event detector top level
// per-key record memory with read, update and write back, forwarding of the last write
// depends on kpd_pkg
//
// channel   direction  transaction content
// req_*     in         tdata: key_index[2:0], pin_pressed[3], now_ms[35:4], zero fill
// rsp_*     out        tdata: key_number[2:0], click_count[10:3]; tuser: event_kind
// csr_*     in         csr_index selects register, csr_data carries its value
//
// one transaction per cycle unless rsp_tready stalls; result via update and output registers
// the key record memory is read at acceptance and written in the update stage
// a key that matches the last write takes its record from the last-write register
// reset clears per-key valid bits at once; no clearing pass
// rsp_tready low holds the output and the update stage; req_tready drops when both are held
`default_nettype none

module key_press_event_detector #(
   parameter int NUM_KEYS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // key_index, pin_pressed, now_ms, zero fill

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // key_number, click_count, zero fill
   output      logic [1:0]  rsp_tuser,   // event_kind

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int DEPTH  = (NUM_KEYS < 8) ? NUM_KEYS : 8;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration registers
   logic [7:0]  release_mask_ff;
   logic [7:0]  short_mask_ff;
   logic [7:0]  long_mask_ff;
   logic [7:0]  multi_mask_ff;
   logic [15:0] debounce_ms_ff;
   logic [15:0] long_press_ms_ff;
   logic [15:0] click_gap_ms_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         release_mask_ff  <= kpd_pkg::RELEASE_TRIGGER_RESET;
         short_mask_ff    <= 8'd0;
         long_mask_ff     <= 8'd0;
         multi_mask_ff    <= 8'd0;
         debounce_ms_ff   <= kpd_pkg::DEBOUNCE_MS_RESET;
         long_press_ms_ff <= kpd_pkg::LONG_PRESS_MS_RESET;
         click_gap_ms_ff  <= kpd_pkg::CLICK_GAP_MS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            kpd_pkg::CSR_RELEASE_TRIGGER: release_mask_ff  <= csr_data[7:0];
            kpd_pkg::CSR_SHORT_ENABLE:    short_mask_ff    <= csr_data[7:0];
            kpd_pkg::CSR_LONG_ENABLE:     long_mask_ff     <= csr_data[7:0];
            kpd_pkg::CSR_MULTI_ENABLE:    multi_mask_ff    <= csr_data[7:0];
            kpd_pkg::CSR_DEBOUNCE_MS:     debounce_ms_ff   <= csr_data;
            kpd_pkg::CSR_LONG_PRESS_MS:   long_press_ms_ff <= csr_data;
            kpd_pkg::CSR_CLICK_GAP_MS:    click_gap_ms_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // input fields
   logic [2:0]  req_key;
   logic        req_pin;
   logic [31:0] req_now;
   logic        req_accept;

   assign req_key    = req_tdata[2:0];
   assign req_pin    = req_tdata[3];
   assign req_now    = req_tdata[35:4];
   assign req_accept = req_tvalid && req_tready;

   // update stage registers
   logic        s1_valid_ff;
   logic [2:0]  s1_key_ff;
   logic        s1_pin_ff;
   logic [31:0] s1_now_ff;
   logic        s1_key_ok_ff;
   logic        s1_advance;

   // output registers
   logic        rsp_valid_ff;
   logic [2:0]  rsp_key_ff;
   logic [1:0]  rsp_kind_ff;
   logic [7:0]  rsp_count_ff;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   // key record memory
   kpd_pkg::key_rec_type mem [DEPTH];
   logic [DEPTH-1:0]     vld_ff;
   kpd_pkg::key_rec_type rd_rec_ff;
   logic                 rd_vld_ff;

   // last write register
   logic                 fwd_valid_ff;
   logic [ADDR_W-1:0]    fwd_addr_ff;
   kpd_pkg::key_rec_type fwd_rec_ff;

   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 wr_en;
   kpd_pkg::key_rec_type rec_in;

   assign rd_addr = req_key[ADDR_W-1:0];
   assign wr_addr = s1_key_ff[ADDR_W-1:0];
   assign wr_en   = s1_advance && s1_key_ok_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_rec_ff <= mem[rd_addr];
         rd_vld_ff <= vld_ff[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         fwd_valid_ff <= 1'b0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
         fwd_valid_ff    <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_rec_ff  <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_key_ff    <= req_key;
         s1_pin_ff    <= req_pin;
         s1_now_ff    <= req_now;
         s1_key_ok_ff <= (32'(req_key) < NUM_KEYS);
      end
   end

   // record update
   kpd_pkg::key_rec_type cur;
   kpd_pkg::event_type   kind_in;
   logic [7:0]           count_in;
   logic [31:0]          since_release;
   logic [31:0]          since_press;
   logic                 on_release;
   logic                 short_en;
   logic                 long_en;
   logic                 multi_en;

   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == wr_addr) begin
         cur = fwd_rec_ff;
      end else if (rd_vld_ff) begin
         cur = rd_rec_ff;
      end else begin
         cur = kpd_pkg::KEY_REC_RESET;
      end

      on_release    = release_mask_ff[s1_key_ff];
      short_en      = short_mask_ff[s1_key_ff];
      long_en       = long_mask_ff[s1_key_ff];
      multi_en      = multi_mask_ff[s1_key_ff];
      since_release = s1_now_ff - cur.release_time;
      since_press   = s1_now_ff - cur.press_start_time;

      rec_in   = cur;
      kind_in  = kpd_pkg::EV_NONE;
      count_in = 8'd0;

      case (cur.phase)
         kpd_pkg::PH_RELEASED: begin
            if (cur.held_flag && on_release && since_release >= 32'(click_gap_ms_ff)) begin
               rec_in.release_time = 32'd0;
               if (cur.click_tally >= kpd_pkg::MULTI_MIN_CLICKS && multi_en) begin
                  kind_in  = kpd_pkg::EV_MULTI;
                  count_in = cur.click_tally;
               end else if (short_en) begin
                  kind_in = kpd_pkg::EV_SHORT;
               end
               rec_in.click_tally = 8'd0;
               rec_in.held_flag   = 1'b0;
            end else if (s1_pin_ff) begin
               rec_in.phase            = kpd_pkg::PH_DEBOUNCE;
               rec_in.press_start_time = s1_now_ff;
            end
         end
         kpd_pkg::PH_DEBOUNCE: begin
            if (since_press > 32'(debounce_ms_ff)) begin
               if (s1_pin_ff) begin
                  rec_in.held_flag        = 1'b1;
                  rec_in.press_start_time = s1_now_ff;
                  rec_in.phase            = kpd_pkg::PH_PRESSED;
               end else begin
                  rec_in.held_flag = 1'b0;
                  rec_in.phase     = kpd_pkg::PH_RELEASED;
               end
            end
         end
         kpd_pkg::PH_PRESSED: begin
            if (!on_release && !cur.short_fired && short_en) begin
               kind_in            = kpd_pkg::EV_SHORT;
               rec_in.short_fired = 1'b1;
            end else if (s1_pin_ff) begin
               if (since_press >= 32'(long_press_ms_ff)) begin
                  rec_in.phase = kpd_pkg::PH_LONG;
               end
            end else begin
               if (cur.click_tally != kpd_pkg::TALLY_MAX) begin
                  rec_in.click_tally = cur.click_tally + 8'd1;
               end
               rec_in.short_fired  = 1'b0;
               rec_in.release_time = s1_now_ff;
               rec_in.phase        = kpd_pkg::PH_RELEASED;
            end
         end
         default: begin
            if (!s1_pin_ff) begin
               rec_in.short_fired = 1'b0;
               rec_in.long_fired  = 1'b0;
               rec_in.phase       = kpd_pkg::PH_RELEASED;
               if (long_en && on_release) begin
                  kind_in = kpd_pkg::EV_LONG;
               end
               rec_in.click_tally  = 8'd0;
               rec_in.release_time = s1_now_ff;
               rec_in.held_flag    = 1'b0;
            end else if (long_en && !on_release && !cur.long_fired) begin
               kind_in           = kpd_pkg::EV_LONG;
               rec_in.long_fired = 1'b1;
            end
         end
      endcase

      if (!s1_key_ok_ff) begin
         kind_in  = kpd_pkg::EV_NONE;
         count_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_key_ff   <= s1_key_ff;
         rsp_kind_ff  <= kind_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_count_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_kind_ff;

   // checks
   a_multi_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == kpd_pkg::EV_MULTI |-> rsp_count_ff >= kpd_pkg::MULTI_MIN_CLICKS)
      else $error("multi-click with fewer than two clicks");

   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != kpd_pkg::EV_MULTI |-> rsp_count_ff == 8'd0)
      else $error("click count on a non multi-click result");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted transaction lost before update stage");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_key_ff) && $stable(s1_now_ff))
      else $error("stalled update stage changed");

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s1_valid_ff && (!rsp_valid_ff || rsp_tready))
      else $error("record written without a transaction leaving");

endmodule

`default_nettype wire
